FILE: rtl/hts_pkg.sv
// Shared types and constants for the hysteresis thermostat setpoint block.
// No dependencies; every other file in rtl/ imports this package.
package hts_pkg;

  // Field widths
  localparam int unsigned AdcW   = 10;
  localparam int unsigned GainW  = 3;
  localparam int unsigned TempW  = 9;
  localparam int unsigned LimW   = 8;

  // Divide by ten as a multiply by ceil(2^19 / 10) and a shift; exact for
  // every product code * gain below 2^16.
  localparam int unsigned RecipShift = 19;
  localparam int unsigned RecipW     = 16;
  localparam logic [RecipW-1:0] Recip10 = 16'd52429;
  // Scaled gain: gain * Recip10, at most 7 * 52429, fits in 19 bits
  localparam int unsigned ScaleW = GainW + RecipW;
  localparam int unsigned ProdW  = AdcW + ScaleW;
  // Quotient bits taken from the product (max 716)
  localparam int unsigned QuotW  = ProdW - RecipShift;

  localparam logic [GainW-1:0] GainReset = 3'd1;
  localparam logic [TempW-1:0] TempMax   = 9'd511;

  localparam logic signed [LimW-1:0] LowerReset = 8'sd20;
  localparam logic signed [LimW-1:0] UpperReset = 8'sd25;
  localparam logic signed [LimW-1:0] LimMax     = 8'sd127;
  localparam logic signed [LimW-1:0] LimMin     = -8'sd128;

  // Item kinds
  localparam logic KindSample = 1'b0;
  localparam logic KindButton = 1'b1;

  typedef enum logic [1:0] {
    MODE_SHOW      = 2'd0,
    MODE_EDIT_LOW  = 2'd1,
    MODE_EDIT_HIGH = 2'd2
  } mode_e;

  // Architectural state; it is also the result shown on the output
  typedef struct packed {
    logic                   motor_on;
    logic [TempW-1:0]       temperature;
    mode_e                  mode;
    logic signed [LimW-1:0] lower;
    logic signed [LimW-1:0] upper;
  } state_t;

  typedef struct packed {
    logic mode_b;
    logic up_b;
    logic down_b;
  } buttons_t;

endpackage

FILE: rtl/hysteresis_thermostat_setpoint.sv
// Top level of the hysteresis thermostat with setpoint editor.
// Depends on hts_pkg, hts_sample and hts_keys.
//
// Every input beat (an ADC sample or a button event) yields one output beat
// holding the motor drive, stored temperature, edit mode and both limits as
// they stand after that beat. Throughput is one beat per clock while the
// output is not stalled. A result beat passes the input register, then the
// state and result register, before it is offered. The sample path is one
// 10x19 multiply by the gain pre-scaled with the reciprocal of ten, which
// sets the critical path. The gain register may be written only while no
// beats are in flight; cfg_ready_o is always high. Reset values: gain 1,
// limits 20 and 25, motor off, mode show.
module hysteresis_thermostat_setpoint (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration: reference gain
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_data_i,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // adc_code[9:0], mode_button[10], up_button[11],
                                     // down_button[12], zero[15:13]
  input  logic        s_axis_tuser,  // kind: 0 sample, 1 button event
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata   // motor_on[0], temperature[9:1], display_mode[11:10],
                                     // lower_limit[19:12], upper_limit[27:20], zero[31:28]
);
  import hts_pkg::*;

  logic [ScaleW-1:0] gain_scaled_q;
  logic [ScaleW-1:0] gain_scaled_d;

  logic              in_valid_q;
  logic              in_kind_q;
  logic [AdcW-1:0]   in_adc_q;
  buttons_t          in_btn_q;

  logic              out_valid_q;
  state_t            state_q;
  state_t            state_d;

  logic              out_free;
  logic              advance;
  logic              in_take;

  logic [TempW-1:0]       smp_temp;
  logic                   smp_motor;
  mode_e                  key_mode;
  logic signed [LimW-1:0] key_lower;
  logic signed [LimW-1:0] key_upper;

  // handshake: output slot frees when empty or taken this cycle
  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;
  assign in_take       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  // gain stored pre-multiplied by the reciprocal of ten
  assign gain_scaled_d = ScaleW'(cfg_data_i) * ScaleW'(Recip10);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_scaled_q <= ScaleW'(GainReset) * ScaleW'(Recip10);
    end else if (cfg_valid_i) begin
      gain_scaled_q <= gain_scaled_d;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_kind_q       <= s_axis_tuser;
      in_adc_q        <= s_axis_tdata[AdcW-1:0];
      in_btn_q.mode_b <= s_axis_tdata[10];
      in_btn_q.up_b   <= s_axis_tdata[11];
      in_btn_q.down_b <= s_axis_tdata[12];
    end
  end

  hts_sample u_sample (
    .adc_code_i    (in_adc_q),
    .gain_scaled_i (gain_scaled_q),
    .state_i       (state_q),
    .temperature_o (smp_temp),
    .motor_on_o    (smp_motor)
  );

  hts_keys u_keys (
    .buttons_i (in_btn_q),
    .state_i   (state_q),
    .mode_o    (key_mode),
    .lower_o   (key_lower),
    .upper_o   (key_upper)
  );

  // next state from whichever path the beat selects
  always_comb begin
    state_d = state_q;
    if (in_kind_q == KindSample) begin
      state_d.temperature = smp_temp;
      state_d.motor_on    = smp_motor;
    end else begin
      state_d.mode  = key_mode;
      state_d.lower = key_lower;
      state_d.upper = key_upper;
    end
  end

  // state doubles as the result register: it only changes when a beat
  // moves into the free output slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.motor_on    <= 1'b0;
      state_q.temperature <= '0;
      state_q.mode        <= MODE_SHOW;
      state_q.lower       <= LowerReset;
      state_q.upper       <= UpperReset;
      out_valid_q         <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
      if (advance) begin
        state_q <= state_d;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, state_q.upper, state_q.lower, state_q.mode,
                          state_q.temperature, state_q.motor_on};

endmodule

FILE: rtl/hts_sample.sv
// Sample path: ADC code to temperature (scaled-reciprocal divide by ten),
// saturation and hysteresis motor switching. Depends on hts_pkg.
module hts_sample (
  input  logic [hts_pkg::AdcW-1:0]   adc_code_i,
  input  logic [hts_pkg::ScaleW-1:0] gain_scaled_i,
  input  hts_pkg::state_t            state_i,
  output logic [hts_pkg::TempW-1:0]  temperature_o,
  output logic                       motor_on_o
);
  import hts_pkg::*;

  logic [ProdW-1:0]       prod;
  logic [QuotW-1:0]       quot;
  logic [TempW-1:0]       temp;
  logic signed [TempW:0]  temp_s;
  logic signed [TempW:0]  lower_s;
  logic signed [TempW:0]  upper_s;

  // code * gain / 10 in a single multiply
  assign prod = ProdW'(adc_code_i) * ProdW'(gain_scaled_i);
  assign quot = prod[ProdW-1:RecipShift];

  // saturate at the 9-bit range
  assign temp = (quot > QuotW'(TempMax)) ? TempMax : quot[TempW-1:0];

  // signed compare against the limits
  assign temp_s  = signed'({1'b0, temp});
  assign lower_s = {{(TempW+1-LimW){state_i.lower[LimW-1]}}, state_i.lower};
  assign upper_s = {{(TempW+1-LimW){state_i.upper[LimW-1]}}, state_i.upper};

  // off wins when both thresholds are met
  always_comb begin
    motor_on_o = state_i.motor_on;
    if (temp_s >= upper_s) begin
      motor_on_o = 1'b1;
    end
    if (temp_s <= lower_s) begin
      motor_on_o = 1'b0;
    end
  end

  assign temperature_o = temp;

endmodule

FILE: rtl/hts_keys.sv
// Button path: edit-mode stepping and saturating limit adjustment.
// Depends on hts_pkg.
module hts_keys (
  input  hts_pkg::buttons_t              buttons_i,
  input  hts_pkg::state_t                state_i,
  output hts_pkg::mode_e                 mode_o,
  output logic signed [hts_pkg::LimW-1:0] lower_o,
  output logic signed [hts_pkg::LimW-1:0] upper_o
);
  import hts_pkg::*;

  mode_e                  mode_n;
  logic signed [LimW-1:0] lo_up;
  logic signed [LimW-1:0] hi_up;
  logic signed [LimW-1:0] lo_dn;
  logic signed [LimW-1:0] hi_dn;

  // mode button cycles show -> edit low -> edit high -> show
  always_comb begin
    mode_n = state_i.mode;
    if (buttons_i.mode_b) begin
      case (state_i.mode)
        MODE_SHOW:     mode_n = MODE_EDIT_LOW;
        MODE_EDIT_LOW: mode_n = MODE_EDIT_HIGH;
        default:       mode_n = MODE_SHOW;
      endcase
    end
  end

  // up first; raising the lower limit drags the upper one along
  always_comb begin
    lo_up = state_i.lower;
    hi_up = state_i.upper;
    if (buttons_i.up_b) begin
      case (mode_n)
        MODE_EDIT_LOW: begin
          if (state_i.lower != LimMax) begin
            lo_up = state_i.lower + 8'sd1;
          end
          if (lo_up > hi_up) begin
            hi_up = lo_up;
          end
        end
        MODE_EDIT_HIGH: begin
          if (state_i.upper != LimMax) begin
            hi_up = state_i.upper + 8'sd1;
          end
        end
        default: ;
      endcase
    end
  end

  // then down; the upper limit never goes below the lower one
  always_comb begin
    lo_dn = lo_up;
    hi_dn = hi_up;
    if (buttons_i.down_b) begin
      case (mode_n)
        MODE_EDIT_LOW: begin
          if (lo_up != LimMin) begin
            lo_dn = lo_up - 8'sd1;
          end
        end
        MODE_EDIT_HIGH: begin
          if (hi_up > lo_up) begin
            hi_dn = hi_up - 8'sd1;
          end
        end
        default: ;
      endcase
    end
  end

  assign mode_o  = mode_n;
  assign lower_o = lo_dn;
  assign upper_o = hi_dn;

endmodule

FILE: tb/hysteresis_thermostat_setpoint_tb.sv
// Self-checking testbench for the hysteresis thermostat setpoint block.
// Depends on hts_pkg and hysteresis_thermostat_setpoint from rtl/.
// A local predictor follows every accepted beat; results are checked in order.
module hysteresis_thermostat_setpoint_tb;
  import hts_pkg::*;

  localparam int StallLimit = 3000;  // cycles with no beat moving on any channel

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;  // adc_code[9:0], mode_button[10], up_button[11],
                              // down_button[12], zero[15:13]
  logic        s_axis_tuser;  // kind: 0 sample, 1 button event
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;  // motor_on[0], temperature[9:1], display_mode[11:10],
                              // lower_limit[19:12], upper_limit[27:20], zero[31:28]

  hysteresis_thermostat_setpoint dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // Clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Thermostat state as the predictor sees it
  logic                   th_motor;
  logic [TempW-1:0]       th_temp;
  mode_e                  th_mode;
  logic signed [LimW-1:0] th_lower;
  logic signed [LimW-1:0] th_upper;
  logic [GainW-1:0]       th_gain;

  state_t pending_results[$];

  int  mismatches;
  int  beats_sent;
  int  results_checked;
  int  lower_sat_hits;
  int  upper_sat_hits;
  int  quiet_cycles;
  bit  src_gaps;
  bit  sink_gaps;
  int  hold_request;
  int  hold_left;

  // Apply one accepted beat to the thermostat state and return the new state
  function automatic state_t advance_thermostat(logic kind, logic [AdcW-1:0] code,
                                                buttons_t b);
    int unsigned quot;
    state_t      r;
    if (kind == KindSample) begin
      quot = (32'(code) * 32'(th_gain)) / 10;
      if (quot > 511) quot = 511;
      th_temp = quot[TempW-1:0];
      if (int'(th_temp) >= int'(th_upper)) th_motor = 1'b1;
      // off wins when both limits are met
      if (int'(th_temp) <= int'(th_lower)) th_motor = 1'b0;
    end else begin
      if (b.mode_b)
        th_mode = (th_mode == MODE_EDIT_HIGH) ? MODE_SHOW : mode_e'(th_mode + 2'd1);
      if (b.up_b) begin
        if (th_mode == MODE_EDIT_LOW) begin
          if (th_lower != LimMax) th_lower = th_lower + 8'sd1;
          if (th_lower > th_upper) th_upper = th_lower;
        end else if (th_mode == MODE_EDIT_HIGH) begin
          if (th_upper != LimMax) th_upper = th_upper + 8'sd1;
        end
      end
      if (b.down_b) begin
        if (th_mode == MODE_EDIT_LOW) begin
          if (th_lower != LimMin) th_lower = th_lower - 8'sd1;
        end else if (th_mode == MODE_EDIT_HIGH) begin
          // upper never drops below lower
          if (th_upper > th_lower) th_upper = th_upper - 8'sd1;
        end
      end
    end
    if (th_lower == LimMax || th_lower == LimMin) lower_sat_hits++;
    if (th_upper == LimMax || th_upper == LimMin) upper_sat_hits++;
    r.motor_on    = th_motor;
    r.temperature = th_temp;
    r.mode        = th_mode;
    r.lower       = th_lower;
    r.upper       = th_upper;
    return r;
  endfunction

  task automatic flag_mismatch(string field, int want, int got);
    mismatches++;
    $display("[%0t] mismatch on %s: expected %0d, got %0d", $realtime, field, want, got);
  endtask

  // Predict on accepted inputs, check accepted outputs, track gain writes
  always @(posedge clk_i) begin
    state_t   want;
    buttons_t b;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_results.size() == 0) begin
          flag_mismatch("unexpected result beat", 0, 1);
        end else begin
          want = pending_results.pop_front();
          results_checked++;
          if (m_axis_tdata[0] !== want.motor_on)
            flag_mismatch("motor_on", int'(want.motor_on), int'(m_axis_tdata[0]));
          if (m_axis_tdata[9:1] !== want.temperature)
            flag_mismatch("temperature", int'(want.temperature), int'(m_axis_tdata[9:1]));
          if (m_axis_tdata[11:10] !== want.mode)
            flag_mismatch("display_mode", int'(want.mode), int'(m_axis_tdata[11:10]));
          if (m_axis_tdata[19:12] !== want.lower)
            flag_mismatch("lower_limit", int'(want.lower), int'($signed(m_axis_tdata[19:12])));
          if (m_axis_tdata[27:20] !== want.upper)
            flag_mismatch("upper_limit", int'(want.upper), int'($signed(m_axis_tdata[27:20])));
        end
      end
      if (cfg_valid_i && cfg_ready_o) th_gain = cfg_data_i;
      if (s_axis_tvalid && s_axis_tready) begin
        b.mode_b = s_axis_tdata[10];
        b.up_b   = s_axis_tdata[11];
        b.down_b = s_axis_tdata[12];
        pending_results.push_back(advance_thermostat(s_axis_tuser, s_axis_tdata[9:0], b));
      end
    end
  end

  // Output side: random stalls plus an occasional long hold-off
  always @(posedge clk_i) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !(sink_gaps && $urandom_range(99) < 6);
    end
  end

  // Watchdog on cycles where nothing moves
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("[%0t] no beat moved for %0d cycles", $realtime, StallLimit);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Send one input beat, with an occasional idle gap first
  task automatic send_beat(logic kind, logic [AdcW-1:0] code, buttons_t b);
    if (src_gaps && $urandom_range(99) < 6) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {3'b000, b.down_b, b.up_b, b.mode_b, code};
    do @(posedge clk_i); while (!s_axis_tready);
    beats_sent++;
  endtask

  task automatic send_sample(logic [AdcW-1:0] code, buttons_t junk);
    send_beat(KindSample, code, junk);
  endtask

  task automatic send_keys(logic m, logic u, logic d, logic [AdcW-1:0] junk);
    buttons_t b;
    b.mode_b = m;
    b.up_b   = u;
    b.down_b = d;
    send_beat(KindButton, junk, b);
  endtask

  // Wait until every result is back and the pipeline is empty
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_gain(logic [GainW-1:0] g);
    drain_results();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= g;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // ADC code aimed at a temperature within two degrees of a limit
  function automatic logic [AdcW-1:0] code_near(int lim);
    int t;
    int c;
    if (th_gain == 0) return AdcW'($urandom_range(1023));
    t = lim + int'($urandom_range(4)) - 2;
    if (t < 0) t = 0;
    c = (t * 10 + int'($urandom_range(9))) / int'(th_gain);
    if (c > 1023) c = 1023;
    return AdcW'(c);
  endfunction

  // ---------------------------------------------------------------- tests

  // Reset values show up on a button event with no button pressed
  task automatic test_reset_values();
    send_keys(1'b0, 1'b0, 1'b0, 10'h3FF);
  endtask

  // Code extremes and the hysteresis band at gain 1; button fields ignored
  task automatic test_sample_range();
    buttons_t all_on;
    buttons_t none;
    all_on = '{mode_b: 1'b1, up_b: 1'b1, down_b: 1'b1};
    none   = '{mode_b: 1'b0, up_b: 1'b0, down_b: 1'b0};
    send_sample(10'd0, all_on);
    send_sample(10'd250, none);     // at upper limit: on
    send_sample(10'd249, all_on);   // inside the band: stays on
    send_sample(10'd201, none);
    send_sample(10'd200, none);     // at lower limit: off
    send_sample(10'd1023, all_on);
    send_sample(10'd9, none);
  endtask

  // Mode cycling, up and down in every mode, both together, ignored code
  task automatic test_button_ops();
    send_keys(1'b1, 1'b0, 1'b0, 10'h155);  // edit lower
    send_keys(1'b0, 1'b1, 1'b0, 10'h2AA);
    send_keys(1'b0, 1'b0, 1'b1, 10'h000);
    send_keys(1'b0, 1'b1, 1'b1, 10'h3FF);  // up then down
    send_keys(1'b1, 1'b1, 1'b0, 10'h0F0);  // mode first, then up on upper
    send_keys(1'b0, 1'b0, 1'b1, 10'h00F);
    send_keys(1'b0, 1'b1, 1'b1, 10'h333);
    send_keys(1'b1, 1'b1, 1'b1, 10'h1CC);  // back to show: keys do nothing
    send_keys(1'b1, 1'b0, 1'b1, 10'h2D2);  // edit lower and step down
  endtask

  // Gain zero and the saturating top of the temperature range
  task automatic test_gain_extremes();
    buttons_t none;
    none = '{mode_b: 1'b0, up_b: 1'b0, down_b: 1'b0};
    write_gain(3'd0);
    send_sample(10'd1023, none);
    write_gain(3'd7);
    send_sample(10'd1023, none);
    send_sample(10'd730, none);
    send_sample(10'd731, none);
    send_sample(10'd72, none);
  endtask

  // Mixed traffic: samples near and away from the limits, key runs, noise
  task automatic test_random_traffic(int beats);
    int       left;
    int       run;
    int       pick;
    logic     dir_up;
    buttons_t junk;
    left = beats;
    while (left > 0) begin
      pick = $urandom_range(99);
      junk = buttons_t'(3'($urandom_range(7)));
      if (pick < 40) begin
        if ($urandom_range(1))
          send_sample(AdcW'($urandom_range(1023)), junk);
        else if ($urandom_range(1))
          send_sample(code_near(int'(th_upper)), junk);
        else
          send_sample(code_near(int'(th_lower)), junk);
        left--;
      end else if (pick < 85) begin
        // select a mode, then a run of one key; long runs reach saturation
        repeat ($urandom_range(2)) begin
          send_keys(1'b1, 1'b0, 1'b0, AdcW'($urandom_range(1023)));
          left--;
        end
        run = ($urandom_range(4) == 0) ? $urandom_range(20, 150) : $urandom_range(1, 8);
        // keep the phase close to its beat budget
        if (run > left) run = (left < 1) ? 1 : left;
        dir_up = 1'($urandom_range(1));
        repeat (run) begin
          send_keys(1'b0, dir_up, !dir_up, AdcW'($urandom_range(1023)));
          left--;
        end
      end else begin
        send_keys(1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                  AdcW'($urandom_range(1023)));
        left--;
      end
    end
  endtask

  // Output held off for a long stretch while the input keeps offering beats
  task automatic test_output_backpressure();
    src_gaps = 1'b0;
    hold_request = 300;
    test_random_traffic(80);
    src_gaps = 1'b1;
  endtask

  // ---------------------------------------------------------------- sequence
  initial begin
    logic [GainW-1:0] gains[8];
    gains = '{3'd0, 3'd7, 3'd5, 3'd3, 3'd6, 3'd2, 3'd4, 3'd1};
    clk_i         = 1'b0;
    rst_ni        <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_data_i    <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= 1'b0;
    m_axis_tready <= 1'b0;
    th_motor = 1'b0;
    th_temp  = '0;
    th_mode  = MODE_SHOW;
    th_lower = LowerReset;
    th_upper = UpperReset;
    th_gain  = GainReset;
    src_gaps = 1'b1;
    sink_gaps = 1'b1;
    hold_request = 0;
    hold_left = 0;
    quiet_cycles = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_values();
    test_sample_range();
    test_button_ops();
    test_gain_extremes();
    test_output_backpressure();

    foreach (gains[i]) begin
      write_gain(gains[i]);
      // one phase runs with no idling on either side
      src_gaps  = (gains[i] != 3'd3);
      sink_gaps = (gains[i] != 3'd3);
      test_random_traffic(185);
    end
    src_gaps  = 1'b1;
    sink_gaps = 1'b1;

    drain_results();
    repeat (10) @(posedge clk_i);
    $display("Sent %0d beats and checked %0d results across gains 0 to 7.",
             beats_sent, results_checked);
    $display("Limits sat at a rail on %0d (lower) and %0d (upper) beats; %0d mismatches.",
             lower_sat_hits, upper_sat_hits, mismatches);
    if (mismatches == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/hts_pkg.sv
rtl/hts_sample.sv
rtl/hts_keys.sv
rtl/hysteresis_thermostat_setpoint.sv
tb/hysteresis_thermostat_setpoint_tb.sv
